// ===== sv/lpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants, defaults and control structures of the page engine.
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 8;

	localparam int CFG_BITS        = 4;
	localparam int FRAME_IDX_BITS  = 3;
	localparam int EVICT_PAGE_BITS = 8;
	localparam int FAULT_BITS      = 16;
	localparam int M_TDATA_BITS    = 32;

	localparam logic [CFG_BITS-1:0]   FRAMES_IN_USE_RST = 4'd8;
	localparam logic [FAULT_BITS-1:0] FAULT_MAX         = 16'hFFFF;

	// Control of the shared compare unit.
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	// Summary of one completed scan.
	typedef struct packed {
		logic hit;
		logic found;
	} scan_res_t;

	// Recency update request for the frame store.
	typedef struct packed {
		logic en;
		logic write_page;
	} touch_t;

endpackage
`default_nettype wire

// ===== sv/lpr_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU scan unit
// One tag compare and one age compare, applied to one frame per cycle while
// step is set. It tracks the first matching frame and the oldest valid frame of a scan.
// ----------------------------------------------------------------------------
module lpr_scan #(
	parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
	localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpr_pkg::scan_ctl_t    ctl,
	input  logic [IDX_W-1:0]      idx,
	input  logic                  ent_valid,
	input  logic [PAGE_BITS-1:0]  ent_page,
	input  logic [IDX_W-1:0]      ent_age,
	input  logic [PAGE_BITS-1:0]  query,
	output lpr_pkg::scan_res_t    res,
	output logic [IDX_W-1:0]      hit_idx,
	output logic [IDX_W-1:0]      best_idx
);
	import lpr_pkg::*;

	logic             hit_q;
	logic             found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] best_age_q;
	logic             tag_match;
	logic             older;

	assign tag_match = ent_valid && (ent_page == query);
	assign older     = ent_valid && (!found_q || (ent_age > best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.step) begin
			// Only the lowest matching frame counts as the hit.
			if (!hit_q && tag_match) begin
				hit_q <= 1'b1;
			end
			if (older) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (!hit_q && tag_match) begin
				hit_idx_q <= idx;
			end
			if (older) begin
				best_idx_q <= idx;
				best_age_q <= ent_age;
			end
		end
	end

	assign res.hit   = hit_q;
	assign res.found = found_q;
	assign hit_idx   = hit_idx_q;
	assign best_idx  = best_idx_q;

endmodule
`default_nettype wire

// ===== sv/lpr_fstore.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame store
// Page, valid bit and age rank of each frame, with one read port and the
// recency update that makes one frame the most recently used.
// ----------------------------------------------------------------------------
module lpr_fstore #(
	parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
	localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int CNT_W    = $clog2(FRAMES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      rd_idx,
	output logic                  rd_valid,
	output logic [PAGE_BITS-1:0]  rd_page,
	output logic [IDX_W-1:0]      rd_age,
	input  lpr_pkg::touch_t       touch,
	input  logic [PAGE_BITS-1:0]  wr_page
);
	import lpr_pkg::*;

	logic [PAGE_BITS-1:0] pages_q [FRAMES];
	logic                 valid_q [FRAMES];
	logic [IDX_W-1:0]     age_q   [FRAMES];
	logic [CNT_W-1:0]     old_rank;

	assign rd_valid = valid_q[rd_idx];
	assign rd_page  = pages_q[rd_idx];
	assign rd_age   = age_q[rd_idx];

	// A frame that was empty ranks older than every valid frame.
	assign old_rank = rd_valid ? CNT_W'(rd_age) : CNT_W'(FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
		end else if (touch.en) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (IDX_W'(i) == rd_idx) begin
					valid_q[i] <= 1'b1;
					age_q[i]   <= '0;
				end else if (valid_q[i] && (CNT_W'(age_q[i]) < old_rank)) begin
					age_q[i] <= age_q[i] + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (touch.en && touch.write_page) begin
			pages_q[rd_idx] <= wr_page;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lru_page_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement engine
// Fully associative page frames with least-recently-used eviction.
// ----------------------------------------------------------------------------
// Each transaction on the slave side carries one page reference. The engine
// scans the managed frames (frames_in_use, clamped to 1..FRAMES) one per
// cycle through a single compare unit, then updates the frame and the
// recency ranks once the output register is free. The result waits in
// an output register, and the next reference is taken while it waits.
// Writing the configuration register is allowed only while no reference
// is in flight.
module lru_page_replacement #(
	parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
	localparam int S_TDATA_W = ((PAGE_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [S_TDATA_W-1:0]                s_tdata,  // page
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// fault, frame_index[2:0], evicted_valid, evicted_page[7:0], fault_total[15:0]
	output logic [lpr_pkg::M_TDATA_BITS-1:0]    m_tdata,
	input  logic                                cfg_wr_en,
	input  logic [lpr_pkg::CFG_BITS-1:0]        cfg_wr_data
);
	import lpr_pkg::*;

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int CMP_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t                  state_q;
	logic [PAGE_BITS-1:0]    page_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        scan_q;
	logic [CNT_W-1:0]        filled_q;
	logic [FAULT_BITS-1:0]   fault_cnt_q;
	logic [CFG_BITS-1:0]     cfg_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;

	logic [CMP_W-1:0]        cfg_ext;
	logic [CNT_W-1:0]        n_eff;
	scan_ctl_t               scan_ctl;
	scan_res_t               scan_res;
	logic [IDX_W-1:0]        hit_idx;
	logic [IDX_W-1:0]        best_idx;
	logic [IDX_W-1:0]        rd_idx;
	logic                    rd_valid;
	logic [PAGE_BITS-1:0]    rd_page;
	logic [IDX_W-1:0]        rd_age;
	logic                    is_fill;
	logic [IDX_W-1:0]        f_idx;
	logic                    out_free;
	logic                    upd_go;
	touch_t                  touch;
	logic                    evicted;
	logic [FAULT_BITS-1:0]   fault_next;
	logic [M_TDATA_BITS-1:0] result;

	assign cfg_ext = CMP_W'(cfg_q);

	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (cfg_ext > CMP_W'(FRAMES)) begin
			n_eff = CNT_W'(FRAMES);
		end else begin
			n_eff = CNT_W'(cfg_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign scan_ctl.clear = s_tvalid && s_tready;
	assign scan_ctl.step  = (state_q == ST_SCAN);

	// Empty frames are filled in index order before any eviction.
	assign is_fill = (filled_q < n_q);

	always_comb begin
		if (scan_res.hit) begin
			f_idx = hit_idx;
		end else if (is_fill) begin
			f_idx = filled_q[IDX_W-1:0];
		end else begin
			f_idx = best_idx;
		end
	end

	assign rd_idx   = (state_q == ST_UPDATE) ? f_idx : scan_q[IDX_W-1:0];
	assign out_free = !m_tvalid_q || m_tready;
	assign upd_go   = (state_q == ST_UPDATE) && out_free;

	assign touch.en         = upd_go;
	assign touch.write_page = !scan_res.hit;

	assign evicted = !scan_res.hit && rd_valid && (is_fill || scan_res.found);

	always_comb begin
		if (scan_res.hit || (fault_cnt_q == FAULT_MAX)) begin
			fault_next = fault_cnt_q;
		end else begin
			fault_next = fault_cnt_q + FAULT_BITS'(1);
		end
	end

	always_comb begin
		result        = '0;
		result[0]     = !scan_res.hit;
		result[3:1]   = FRAME_IDX_BITS'(f_idx);
		result[4]     = evicted;
		result[12:5]  = evicted ? EVICT_PAGE_BITS'(rd_page) : '0;
		result[28:13] = fault_next;
	end

	lpr_scan #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.idx       (scan_q[IDX_W-1:0]),
		.ent_valid (rd_valid),
		.ent_page  (rd_page),
		.ent_age   (rd_age),
		.query     (page_q),
		.res       (scan_res),
		.hit_idx   (hit_idx),
		.best_idx  (best_idx)
	);

	lpr_fstore #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_fstore (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_valid (rd_valid),
		.rd_page  (rd_page),
		.rd_age   (rd_age),
		.touch    (touch),
		.wr_page  (page_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			page_q      <= '0;
			n_q         <= '0;
			scan_q      <= '0;
			filled_q    <= '0;
			fault_cnt_q <= '0;
			cfg_q       <= FRAMES_IN_USE_RST;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (upd_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						page_q  <= s_tdata[PAGE_BITS-1:0];
						n_q     <= n_eff;
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_q == n_q - CNT_W'(1)) begin
						state_q <= ST_UPDATE;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						fault_cnt_q <= fault_next;
						if (!scan_res.hit && is_fill) begin
							filled_q <= filled_q + CNT_W'(1);
						end
						m_tdata_q  <= result;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
